// ===== rtl/core/bfe_pkg.sv =====
package bfe_pkg;

  localparam int WORD_BITS      = 64;
  localparam int FIELD_BITS_MAX = 256;
  localparam int DIGIT_BITS     = 16;
  localparam int PROD_BITS      = FIELD_BITS_MAX + DIGIT_BITS;
  localparam int CNT_BITS       = 4;

  typedef logic [1:0]                field_mode_t;
  typedef logic [FIELD_BITS_MAX-1:0] felem_t;
  typedef logic [DIGIT_BITS-1:0]     digit_t;
  typedef logic [PROD_BITS-1:0]      prod_t;

  localparam field_mode_t MODE_GF64        = 2'd0;
  localparam field_mode_t MODE_GF128       = 2'd1;
  localparam field_mode_t MODE_GF192       = 2'd2;
  localparam field_mode_t MODE_GF256       = 2'd3;
  localparam field_mode_t FIELD_MODE_RESET = MODE_GF128;

  // Request to the shared multiplier
  typedef struct packed {
    logic        start;
    field_mode_t mode;
  } mul_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_FINISH
  } seq_state_t;

  // Keep only the coefficients below the field width
  function automatic felem_t field_mask(field_mode_t m);
    felem_t mask;
    case (m)
      MODE_GF64:  mask = felem_t'({64{1'b1}});
      MODE_GF128: mask = felem_t'({128{1'b1}});
      MODE_GF192: mask = felem_t'({192{1'b1}});
      default:    mask = {FIELD_BITS_MAX{1'b1}};
    endcase
    return mask;
  endfunction

  // Fold a digit that sits at x^n back down: x^n = 1 + low terms of the modulus
  function automatic felem_t fold_overflow(digit_t h, field_mode_t m);
    felem_t hz;
    felem_t f;
    hz = felem_t'(h);
    case (m)
      MODE_GF64:  f = hz ^ (hz << 4) ^ (hz << 3) ^ (hz << 1);
      MODE_GF128: f = hz ^ (hz << 7) ^ (hz << 2) ^ (hz << 1);
      MODE_GF192: f = hz ^ (hz << 7) ^ (hz << 2) ^ (hz << 1);
      default:    f = hz ^ (hz << 10) ^ (hz << 5) ^ (hz << 2);
    endcase
    return f;
  endfunction

  // Pick the digit that spilled just above the field width
  function automatic digit_t top_digit(prod_t t, field_mode_t m);
    digit_t d;
    case (m)
      MODE_GF64:  d = t[64 +: DIGIT_BITS];
      MODE_GF128: d = t[128 +: DIGIT_BITS];
      MODE_GF192: d = t[192 +: DIGIT_BITS];
      default:    d = t[256 +: DIGIT_BITS];
    endcase
    return d;
  endfunction

  // Move the top coefficient of the field to the top of the register
  function automatic felem_t align_left(felem_t b, field_mode_t m);
    felem_t r;
    case (m)
      MODE_GF64:  r = b << 192;
      MODE_GF128: r = b << 128;
      MODE_GF192: r = b << 64;
      default:    r = b;
    endcase
    return r;
  endfunction

  // Index of the last digit step: four digits per 64-bit word
  function automatic logic [CNT_BITS-1:0] last_digit(field_mode_t m);
    return CNT_BITS'({m, 2'b11});
  endfunction

endpackage

// ===== rtl/core/bfe_if.sv =====
interface bfe_cfg_if;
  logic                 valid;
  logic                 ready;
  bfe_pkg::field_mode_t field_mode;

  modport source(output valid, output field_mode, input ready);
  modport sink(input valid, input field_mode, output ready);
endinterface

interface bfe_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] base_word0;
  logic [63:0] base_word1;
  logic [63:0] base_word2;
  logic [63:0] base_word3;
  logic [63:0] exponent;

  modport source(output valid, output base_word0, output base_word1, output base_word2,
                 output base_word3, output exponent, input ready);
  modport sink(input valid, input base_word0, input base_word1, input base_word2,
               input base_word3, input exponent, output ready);
endinterface

interface bfe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_word0;
  logic [63:0] result_word1;
  logic [63:0] result_word2;
  logic [63:0] result_word3;

  modport source(output valid, output result_word0, output result_word1,
                 output result_word2, output result_word3, input ready);
  modport sink(input valid, input result_word0, input result_word1,
               input result_word2, input result_word3, output ready);
endinterface

// ===== rtl/core/binary_field_exponentiation_unit.sv =====
// Binary-field exponentiation: result = base ^ exponent in GF(2^n).
// cfg_chan writes field_mode (0: n=64, 1: n=128, 2: n=192, 3: n=256); it is
// always ready. Write it only while the unit is idle; the unit does not enforce it.
// Reset selects n=128 and empties the unit and its output register.
// in_chan takes base_word0..3 (word j holds x^(64j)..x^(64j+63)) and the
// exponent; words above the field width are ignored. in_chan.ready is high
// only while no item is in work, so one item is processed at a time.
// out_chan returns result_word0..3, words above the field width are zero.
// Exponent bits are scanned from bit 0 upward by a right-to-left
// square-and-multiply loop driven by one shared digit-serial multiplier,
// 16 bits of the multiplier operand per cycle. Each field multiplication
// consumes D = 4*(field_mode+1) digits of that operand.
// The result sits in an output register: a stalled receiver delays only the
// hand-over of the next finished result, and a new item is accepted as
// soon as the previous result has moved into that register.
module binary_field_exponentiation_unit #(
  parameter int EXPONENT_BITS = 64
) (
  input logic       clk,
  input logic       rst_n,
  bfe_cfg_if.sink   cfg_chan,
  bfe_in_if.sink    in_chan,
  bfe_out_if.source out_chan
);
  import bfe_pkg::*;

  seq_state_t               state_r;
  seq_state_t               state_nxt;
  field_mode_t              field_mode_r;
  felem_t                   acc_r;
  felem_t                   acc_nxt;
  felem_t                   sq_r;
  felem_t                   sq_nxt;
  logic [EXPONENT_BITS-1:0] exp_r;
  logic [EXPONENT_BITS-1:0] exp_nxt;
  felem_t                   res_r;
  logic                     out_valid_r;
  logic                     out_load;
  mul_req_t                 mul_req;
  felem_t                   mul_opa;
  logic                     mul_done;
  felem_t                   mul_prod;

  bfe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .opa   (mul_opa),
    .opb   (sq_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Sequence squarings and accumulations over the exponent bits
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    exp_nxt       = exp_r;
    mul_req.start = 1'b0;
    mul_req.mode  = field_mode_r;
    mul_opa       = sq_r;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          acc_nxt   = felem_t'(1);
          sq_nxt    = {in_chan.base_word3, in_chan.base_word2,
                       in_chan.base_word1, in_chan.base_word0} & field_mask(field_mode_r);
          exp_nxt   = in_chan.exponent[EXPONENT_BITS-1:0];
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (exp_r == '0) begin
          state_nxt = ST_FINISH;
        end else if (exp_r[0]) begin
          mul_req.start = 1'b1;
          mul_opa       = acc_r;
          state_nxt     = ST_MUL_ACC;
        end else begin
          mul_req.start = 1'b1;
          state_nxt     = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        if (mul_done) begin
          acc_nxt = mul_prod;
          // no set bits left: the remaining squarings do not matter
          if ((exp_r >> 1) == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            mul_req.start = 1'b1;
            state_nxt     = ST_MUL_SQ;
          end
        end
      end
      ST_MUL_SQ: begin
        if (mul_done) begin
          sq_nxt    = mul_prod;
          exp_nxt   = exp_r >> 1;
          state_nxt = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance the sequencer and its working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    exp_r <= exp_nxt;
  end

  // Hold the field mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_mode_r <= FIELD_MODE_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      field_mode_r <= cfg_chan.field_mode;
    end
  end

  // Hold the finished item until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      res_r <= acc_r;
    end
  end

  assign cfg_chan.ready        = 1'b1;
  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_word0 = res_r[0*WORD_BITS +: WORD_BITS];
  assign out_chan.result_word1 = res_r[1*WORD_BITS +: WORD_BITS];
  assign out_chan.result_word2 = res_r[2*WORD_BITS +: WORD_BITS];
  assign out_chan.result_word3 = res_r[3*WORD_BITS +: WORD_BITS];

endmodule

// ===== rtl/core/bfe_mul.sv =====
module bfe_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  bfe_pkg::mul_req_t req,
  input  bfe_pkg::felem_t   opa,
  input  bfe_pkg::felem_t   opb,
  output logic              done,
  output bfe_pkg::felem_t   prod
);
  import bfe_pkg::*;

  felem_t                a_r;
  felem_t                b_r;
  felem_t                p_r;
  felem_t                p_nxt;
  field_mode_t           mode_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r;
  logic                  done_r;
  digit_t                dig;
  digit_t                spill;
  prod_t                 pp;
  prod_t                 acc_shift;

  // One Horner step: p = p * x^16 + a * digit, then fold the spilled digit
  always_comb begin
    dig = b_r[FIELD_BITS_MAX-1 -: DIGIT_BITS];
    pp  = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      if (dig[i]) begin
        pp = pp ^ (prod_t'(a_r) << i);
      end
    end
    acc_shift = {p_r, {DIGIT_BITS{1'b0}}} ^ pp;
    spill     = top_digit(acc_shift, mode_r);
    p_nxt     = (acc_shift[FIELD_BITS_MAX-1:0] & field_mask(mode_r))
                ^ fold_overflow(spill, mode_r);
  end

  // Load operands on start, then consume one digit of b per cycle, top first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= last_digit(req.mode);
        mode_r <= req.mode;
        a_r    <= opa;
        b_r    <= align_left(opb, req.mode);
        p_r    <= '0;
      end else if (busy_r) begin
        p_r   <= p_nxt;
        b_r   <= b_r << DIGIT_BITS;
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule
